// File: sv/pth_pkg.sv
// Package: shared types, constants and the hash pre-mix function of the pointer-tracking hash table.
package pth_pkg;

    localparam int unsigned CapacityDefault = 4096;
    localparam logic [11:0] FillLimitReset  = 12'd3072;
    localparam logic [63:0] MixMult         = 64'hff51afd7ed558ccd;

    localparam logic [1:0] ActAlloc   = 2'd0;
    localparam logic [1:0] ActFree    = 2'd1;
    localparam logic [1:0] ActRealloc = 2'd2;

    localparam logic [1:0] TagEmpty = 2'd0;
    localparam logic [1:0] TagLive  = 2'd1;
    localparam logic [1:0] TagTomb  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] block_address;
        logic [63:0] old_address;
        logic [47:0] block_bytes;
        logic [63:0] site_file;
        logic [30:0] site_line;
    } pth_in_t;

    typedef struct packed {
        logic        found;
        logic        rejected;
        logic [12:0] live_total;
        logic [12:0] used_total;
        logic [31:0] untracked_total;
    } pth_out_t;

    // One slot record: key and payload kept together in one memory word.
    typedef struct packed {
        logic [63:0] key;
        logic [47:0] bytes;
        logic [63:0] file;
        logic [30:0] line;
    } pth_slot_t;

    function automatic logic [63:0] pre_mix(input logic [63:0] x);
        pre_mix = x ^ (x >> 33);
    endfunction

endpackage

// File: sv/pth_ram.sv
// Generic single-port synchronous RAM with registered read.
module pth_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: sv/pth_hash.sv
// Key mix: pre-shift, then partial products registered, then sum, post-shift and index.
module pth_hash
    import pth_pkg::*;
#(
    parameter int unsigned CAPACITY = CapacityDefault
) (
    input  logic                        aclk,
    input  logic [63:0]                 key,
    output logic [$clog2(CAPACITY)-1:0] index
);
    localparam int unsigned IW = $clog2(CAPACITY);

    // Four 32x32 partial products; the high-by-high term drops out mod 2^64.
    logic [63:0] p_ll_reg, p_lh_reg, p_hl_reg;
    logic [63:0] x;
    logic [63:0] prod;

    assign x = pre_mix(key);

    always_ff @(posedge aclk) begin
        p_ll_reg <= x[31:0] * MixMult[31:0];
        p_lh_reg <= x[31:0] * MixMult[63:32];
        p_hl_reg <= x[63:32] * MixMult[31:0];
    end

    assign prod = p_ll_reg + {p_lh_reg[31:0], 32'd0} + {p_hl_reg[31:0], 32'd0};

    // Index is ready in the cycle after the key settles; the engine samples it then.
    assign index = IW'(prod ^ (prod >> 33));
endmodule

// File: sv/pth_engine.sv
// Probe sequencer: read-modify-write over the tag and slot memories.
module pth_engine
    import pth_pkg::*;
#(
    parameter int unsigned CAPACITY = CapacityDefault
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pth_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pth_out_t m_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [11:0] cfg_data
);
    localparam int unsigned IW = $clog2(CAPACITY);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH1, S_HASH2, S_READ, S_PROBE, S_RESULT
    } state_t;

    state_t          state_reg;
    pth_in_t         item_reg;
    logic            phase_reg;   // 0: removal of old address, 1: main operation
    logic [63:0]     key_reg;
    logic [IW-1:0]   idx_reg;
    logic [IW:0]     cnt_reg;
    logic            tomb_ok_reg;
    logic [IW-1:0]   tomb_reg;
    logic [12:0]     live_reg, used_reg;
    logic [31:0]     untracked_reg;
    logic [11:0]     fill_reg;
    logic            found_reg, rejected_reg;
    logic            m_valid_reg;
    pth_out_t        m_data_reg;

    logic [IW-1:0]   hash_idx;
    logic            tag_we, slot_we;
    logic [IW-1:0]   mem_addr;
    logic [1:0]      tag_wdata, tag_rdata;
    pth_slot_t       slot_wdata, slot_rdata;

    pth_hash #(.CAPACITY(CAPACITY)) u_hash (
        .aclk(aclk), .key(key_reg), .index(hash_idx)
    );

    pth_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_tag (
        .aclk(aclk), .we(tag_we), .addr(mem_addr), .wdata(tag_wdata), .rdata(tag_rdata)
    );

    pth_ram #(.WIDTH($bits(pth_slot_t)), .DEPTH(CAPACITY)) u_slot (
        .aclk(aclk), .we(slot_we), .addr(mem_addr), .wdata(slot_wdata), .rdata(slot_rdata)
    );

    logic insert_op, is_empty, is_hit, is_tomb, exhausted;
    assign insert_op = phase_reg && (item_reg.action == ActAlloc ||
                                     item_reg.action == ActRealloc);
    assign is_empty  = tag_rdata == TagEmpty;
    assign is_tomb   = tag_rdata == TagTomb;
    assign is_hit    = tag_rdata == TagLive && slot_rdata.key == key_reg;
    assign exhausted = cnt_reg == (IW+1)'(CAPACITY - 1);

    always_comb begin
        tag_we     = 1'b0;
        slot_we    = 1'b0;
        mem_addr   = idx_reg;
        tag_wdata  = TagLive;
        slot_wdata = '{key: key_reg, bytes: item_reg.block_bytes,
                       file: item_reg.site_file, line: item_reg.site_line};
        case (state_reg)
            S_CLEAR: begin
                tag_we    = 1'b1;
                tag_wdata = TagEmpty;
            end
            S_PROBE: begin
                if (insert_op) begin
                    if (is_hit) begin
                        slot_we = 1'b1;
                    end else if (is_empty) begin
                        tag_we  = 1'b1;
                        slot_we = 1'b1;
                        if (tomb_ok_reg) mem_addr = tomb_reg;
                    end else if (exhausted && (tomb_ok_reg || is_tomb)) begin
                        tag_we  = 1'b1;
                        slot_we = 1'b1;
                        if (tomb_ok_reg) mem_addr = tomb_reg;
                    end
                end else if (is_hit) begin
                    tag_we    = 1'b1;
                    tag_wdata = TagTomb;
                end
            end
            default: ;
        endcase
    end

    assign s_ready   = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Skip test for the current phase: zero keys are not looked up (full-table inserts are refused by the fill limit).
    function automatic logic skip_key(input logic [63:0] k);
        skip_key = k == 64'd0;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            live_reg      <= '0;
            used_reg      <= '0;
            untracked_reg <= '0;
            fill_reg      <= FillLimitReset;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) fill_reg <= cfg_data;
            // A result leaving in RESULT is replaced by the next one there.
            if (m_valid_reg && m_ready && state_reg != S_RESULT) m_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IW'(CAPACITY - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg     <= s_data;
                        found_reg    <= 1'b0;
                        rejected_reg <= 1'b0;
                        if (s_data.action == ActRealloc && !skip_key(s_data.old_address)) begin
                            phase_reg <= 1'b0;
                            key_reg   <= s_data.old_address;
                            state_reg <= S_HASH1;
                        end else if ((s_data.action == ActAlloc ||
                                      s_data.action == ActRealloc ||
                                      s_data.action == ActFree) &&
                                     !skip_key(s_data.block_address)) begin
                            phase_reg <= 1'b1;
                            key_reg   <= s_data.block_address;
                            if (s_data.action != ActFree && used_reg >= {1'b0, fill_reg}) begin
                                rejected_reg <= 1'b1;
                                state_reg    <= S_RESULT;
                            end else begin
                                state_reg <= S_HASH1;
                            end
                        end else begin
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_HASH1: state_reg <= S_HASH2;
                S_HASH2: begin
                    state_reg   <= S_READ;
                    idx_reg     <= hash_idx;
                    cnt_reg     <= '0;
                    tomb_ok_reg <= 1'b0;
                end
                S_READ: state_reg <= S_PROBE;
                S_PROBE: begin
                    if (insert_op) begin
                        if (is_hit) begin
                            found_reg <= 1'b1;
                            state_reg <= S_RESULT;
                        end else if (is_empty) begin
                            live_reg <= live_reg + 1'b1;
                            if (!tomb_ok_reg) used_reg <= used_reg + 1'b1;
                            state_reg <= S_RESULT;
                        end else if (exhausted) begin
                            if (tomb_ok_reg || is_tomb) live_reg <= live_reg + 1'b1;
                            else rejected_reg <= 1'b1;
                            state_reg <= S_RESULT;
                        end else begin
                            if (is_tomb && !tomb_ok_reg) begin
                                tomb_ok_reg <= 1'b1;
                                tomb_reg    <= idx_reg;
                            end
                            idx_reg   <= idx_reg + 1'b1;
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end else if (is_hit || is_empty || exhausted) begin
                        if (is_hit) live_reg <= live_reg - 1'b1;
                        if (phase_reg) begin
                            found_reg <= is_hit;
                            if (!is_hit && untracked_reg != 32'hFFFF_FFFF)
                                untracked_reg <= untracked_reg + 1'b1;
                            state_reg <= S_RESULT;
                        end else if (!skip_key(item_reg.block_address)) begin
                            // Removal done: start the insert of the new address.
                            phase_reg <= 1'b1;
                            key_reg   <= item_reg.block_address;
                            if (used_reg >= {1'b0, fill_reg}) begin
                                rejected_reg <= 1'b1;
                                state_reg    <= S_RESULT;
                            end else begin
                                state_reg <= S_HASH1;
                            end
                        end else begin
                            state_reg <= S_RESULT;
                        end
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{found: found_reg, rejected: rejected_reg,
                                         live_total: live_reg, used_total: used_reg,
                                         untracked_total: untracked_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: sv/pointer_tracking_hash_table_top.sv
// Top level of the pointer-tracking hash table.
// Tracks live allocations keyed by 64-bit address in an open-addressed table.
// Input channel s_*: one item per request (allocate, free, reallocate).
// Result channel m_*: exactly one result item per input item, in order.
// Configuration channel cfg_*: writes fill_limit; always ready, write only when idle.
// Each item passes from acceptance through the hash states HASH1 and HASH2, then for each
// probed slot a memory read and a compare/write, then a state that loads the output
// register; the next item is taken once back in idle. A reallocate with a nonzero old
// address first runs a removal lookup of it, then hashes and probes again for the insert.
// Throughput is set by the probe loop over the single-port tag and slot memories;
// one item is in work at a time, and the next is accepted once the result is
// placed in the output register, even while the receiver still stalls it.
// Items whose key is zero, or inserts refused by the fill limit at acceptance, go
// straight from acceptance to the result state without a lookup.
// After reset the tag memory is cleared slot by slot; s_ready stays low
// meanwhile. Counters reset to zero and fill_limit to 3072.
// A stalled result holds in m_data until taken; no new item enters beyond one.
module pointer_tracking_hash_table_top
    import pth_pkg::*;
#(
    parameter int unsigned CAPACITY = CapacityDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pth_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pth_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);
    pth_engine #(.CAPACITY(CAPACITY)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );
endmodule

// File: verif/pointer_tracking_hash_table_top_tb.sv
// Testbench for the pointer-tracking hash table: directed and random items against a predictor.
module pointer_tracking_hash_table_top_tb;
    import pth_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = 4096;
    localparam logic [1:0] ActNone = 2'd3;
    localparam logic [63:0] AllOnes = 64'hffff_ffff_ffff_ffff;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    pth_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    pth_out_t    m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;

    pointer_tracking_hash_table_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Shadow of the table: tags and keys only, payload is never visible at the port.
    logic [1:0]  shadow_tag [SLOTS];
    logic [63:0] shadow_key [SLOTS];
    logic [12:0] live_cnt;
    logic [12:0] used_cnt;
    logic [31:0] miss_cnt;
    logic [11:0] fill_lim;

    pth_out_t expected_q[$];
    int       mismatches;
    int       items_sent;
    int       results_seen;
    int       found_seen;
    int       rejected_seen;
    bit       steady_send;
    bit       steady_recv;
    int       hold_request;
    int       hold_left;

    function automatic logic [11:0] slot_of(input logic [63:0] addr);
        logic [63:0] x;
        x = addr ^ (addr >> 33);
        x = x * MixMult;
        x = x ^ (x >> 33);
        return x[11:0];
    endfunction

    function automatic logic drop_addr(input logic [63:0] addr);
        logic [11:0] j;
        j = slot_of(addr);
        if (addr == '0) return 1'b0;
        for (int n = 0; n < SLOTS; n++) begin
            if (shadow_tag[j] == TagEmpty) return 1'b0;
            if (shadow_tag[j] == TagLive && shadow_key[j] == addr) begin
                shadow_tag[j] = TagTomb;
                live_cnt--;
                return 1'b1;
            end
            j = j + 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void insert_addr(input logic [63:0] addr, output logic hit,
                                        output logic refused);
        logic [11:0] j;
        int          tomb;
        int          target;
        bit          fresh;
        hit = 1'b0;
        refused = 1'b0;
        tomb = -1;
        target = -1;
        fresh = 1'b0;
        if (addr == '0) return;
        if (used_cnt >= {1'b0, fill_lim}) begin
            refused = 1'b1;
            return;
        end
        j = slot_of(addr);
        for (int n = 0; n < SLOTS; n++) begin
            if (shadow_tag[j] == TagEmpty) begin
                target = j;
                fresh = 1'b1;
                break;
            end
            if (shadow_tag[j] == TagTomb) begin
                if (tomb < 0) tomb = j;
            end else if (shadow_key[j] == addr) begin
                hit = 1'b1;
                return;
            end
            j = j + 1'b1;
        end
        if (tomb >= 0) begin
            target = tomb;
            fresh = 1'b0;
        end
        if (target < 0) begin
            refused = 1'b1;
            return;
        end
        if (fresh) used_cnt++;
        shadow_tag[target] = TagLive;
        shadow_key[target] = addr;
        live_cnt++;
    endfunction

    function automatic pth_out_t predict_result(input pth_in_t it);
        pth_out_t r;
        logic     hit;
        logic     refused;
        hit = 1'b0;
        refused = 1'b0;
        case (it.action)
            ActAlloc: begin
                insert_addr(it.block_address, hit, refused);
            end
            ActFree: begin
                if (it.block_address != '0) begin
                    hit = drop_addr(it.block_address);
                    if (!hit && miss_cnt != '1) miss_cnt++;
                end
            end
            ActRealloc: begin
                void'(drop_addr(it.old_address));
                insert_addr(it.block_address, hit, refused);
            end
            default: ;
        endcase
        r.found = hit;
        r.rejected = refused;
        r.live_total = live_cnt;
        r.used_total = used_cnt;
        r.untracked_total = miss_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got,
                 want);
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random back-pressure, a long hold on request, and the result check.
    always @(posedge aclk) begin
        pth_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("result %0d arrived with nothing expected", results_seen);
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.found !== want.found)
                        report_mismatch("found", m_data.found, want.found);
                    if (m_data.rejected !== want.rejected)
                        report_mismatch("rejected", m_data.rejected, want.rejected);
                    if (m_data.live_total !== want.live_total)
                        report_mismatch("live_total", m_data.live_total, want.live_total);
                    if (m_data.used_total !== want.used_total)
                        report_mismatch("used_total", m_data.used_total, want.used_total);
                    if (m_data.untracked_total !== want.untracked_total)
                        report_mismatch("untracked_total", m_data.untracked_total,
                                        want.untracked_total);
                    found_seen += want.found;
                    rejected_seen += want.rejected;
                end
            end
            if (hold_request > 0) begin
                hold_left <= hold_request;
                hold_request = 0;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (steady_recv) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 49) == 0) hold_left <= $urandom_range(10, 40);
            end
        end
    end

    task automatic send_item(input pth_in_t it);
        int gap;
        gap = steady_send ? 0 : random_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(predict_result(it));
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_fill_limit(input logic [11:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        fill_lim = value;
    endtask

    function automatic pth_in_t make_item(input logic [1:0] act, input logic [63:0] addr,
                                          input logic [63:0] old);
        pth_in_t it;
        it.action = act;
        it.block_address = addr;
        it.old_address = old;
        it.block_bytes = 48'({$urandom, $urandom});
        it.site_file = {$urandom, $urandom};
        it.site_line = 31'($urandom);
        return it;
    endfunction

    function automatic logic [63:0] addr_at_slot(input logic [11:0] idx);
        logic [63:0] a;
        do a = {$urandom, $urandom}; while (slot_of(a) != idx || a == '0);
        return a;
    endfunction

    task automatic test_special_cases();
        pth_in_t it;
        it = make_item(ActAlloc, AllOnes, '0);
        it.block_bytes = '1;
        it.site_file = '1;
        it.site_line = '1;
        send_item(it);
        it = make_item(ActAlloc, 64'd1, '0);
        it.block_bytes = '0;
        it.site_file = '0;
        it.site_line = '0;
        send_item(it);
        send_item(make_item(ActAlloc, AllOnes, AllOnes));
        send_item(make_item(ActAlloc, '0, '0));
        send_item(make_item(ActFree, '0, AllOnes));
        send_item(make_item(ActFree, 64'h1234_5678_9abc_def0, '0));
        send_item(make_item(ActFree, 64'd1, '0));
        send_item(make_item(ActRealloc, 64'h8000_0000_0000_0000, AllOnes));
        send_item(make_item(ActRealloc, 64'h0000_0000_ffff_0000, '0));
        send_item(make_item(ActRealloc, '0, 64'h0000_0000_ffff_0000));
        send_item(make_item(ActNone, 64'h8000_0000_0000_0000, AllOnes));
    endtask

    // Colliding keys at the last slot so the probe wraps and passes a tombstone.
    task automatic test_collisions();
        logic [63:0] chain [5];
        for (int k = 0; k < 5; k++) chain[k] = addr_at_slot(12'hfff);
        for (int k = 0; k < 4; k++) send_item(make_item(ActAlloc, chain[k], '0));
        send_item(make_item(ActFree, chain[1], '0));
        send_item(make_item(ActAlloc, chain[4], '0));
        send_item(make_item(ActFree, chain[3], '0));
        send_item(make_item(ActAlloc, chain[2], '0));
        send_item(make_item(ActRealloc, chain[3], chain[0]));
    endtask

    task automatic test_fill_limit();
        write_fill_limit(12'd4);
        send_item(make_item(ActAlloc, 64'h8000_0000_0000_0000, '0));
        send_item(make_item(ActAlloc, 64'h0bad_cafe_0000_0001, '0));
        send_item(make_item(ActFree, 64'h8000_0000_0000_0000, '0));
    endtask

    task automatic test_random_phase(input logic [11:0] limit, input int count,
                                     input bit with_hold);
        logic [63:0] pool [48];
        logic [63:0] a;
        logic [63:0] b;
        int          r;
        write_fill_limit(limit);
        for (int k = 0; k < 48; k++) pool[k] = {$urandom, $urandom};
        pool[0] = AllOnes;
        pool[1] = 64'd1;
        steady_send = 1'b0;
        steady_recv = 1'b0;
        if (with_hold) hold_request = 400;
        for (int n = 0; n < count; n++) begin
            if (n % 70 == 0) begin
                steady_send = $urandom_range(0, 2) == 0;
                steady_recv = $urandom_range(0, 2) == 0;
            end
            a = ($urandom_range(0, 19) == 0) ? '0 : pool[$urandom_range(0, 47)];
            b = ($urandom_range(0, 9) == 0) ? '0 : pool[$urandom_range(0, 47)];
            if ($urandom_range(0, 14) == 0) a = {$urandom, $urandom};
            r = $urandom_range(0, 99);
            if (r < 40) send_item(make_item(ActAlloc, a, b));
            else if (r < 70) send_item(make_item(ActFree, a, b));
            else if (r < 97) send_item(make_item(ActRealloc, a, b));
            else send_item(make_item(ActNone, a, b));
        end
        steady_send = 1'b0;
        steady_recv = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        found_seen = 0;
        rejected_seen = 0;
        steady_send = 1'b0;
        steady_recv = 1'b0;
        hold_request = 0;
        for (int k = 0; k < SLOTS; k++) shadow_tag[k] = TagEmpty;
        live_cnt = '0;
        used_cnt = '0;
        miss_cnt = '0;
        fill_lim = FillLimitReset;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_special_cases();
        test_collisions();
        test_fill_limit();
        test_random_phase(12'd60, 210, 1'b1);
        test_random_phase(12'd3072, 210, 1'b0);
        test_random_phase(12'd1, 100, 1'b0);
        test_random_phase(12'd4095, 210, 1'b1);
        test_random_phase(12'd600, 300, 1'b0);

        wait_idle();
        repeat (50) @(posedge aclk);
        $display("%0d items sent, %0d results checked (%0d found, %0d refused)",
                 items_sent, results_seen, found_seen, rejected_seen);
        $display("fill limits 1 to 4095, colliding keys with wrap, zero addresses covered");
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("PASS pointer_tracking_hash_table_top");
        end else begin
            $display("FAIL pointer_tracking_hash_table_top");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("FAIL pointer_tracking_hash_table_top");
        $finish;
    end

endmodule
